// File: src/anchor_free_detector_decode_assert.svh
// ----------------------------------------------------------------------------
// anchor free detector decode assertion macros
// shared concurrent assertion forms for the decoder checkers
// ----------------------------------------------------------------------------
`ifndef ANCHOR_FREE_DETECTOR_DECODE_ASSERT_SVH
`define ANCHOR_FREE_DETECTOR_DECODE_ASSERT_SVH

// checked only while out of reset
`define AFD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define AFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/afd_pkg.sv
// ----------------------------------------------------------------------------
// afd_pkg
// constants, types and tables shared by the anchor free detector decoder
// ----------------------------------------------------------------------------
package afd_pkg;

  localparam int MAX_CLASSES       = 80;
  localparam int IMAGE_MAX         = 1024;
  localparam int LEVELS            = 3;
  localparam int VALUE_FRAC_BITS   = 12;

  localparam int BASE_STRIDE_SHIFT = 3;
  localparam int BOX_FIELDS        = 5;
  localparam int LOG2E_Q16         = 94548;
  localparam int Q16               = 16;
  localparam int HALF_Q16          = 1 << (Q16 - 1);
  localparam int IMG_ALIGN         = 5;
  localparam int IMG_MIN           = 32;

  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int VALUE_W     = 16;
  localparam int THR_W       = 16;
  localparam int CFG_IMG_W   = 11;
  localparam int NC_W        = 7;
  localparam int CLASS_W     = 7;
  localparam int CONF_W      = 16;
  localparam int COORD_OUT_W = 13;
  localparam int SIZE_OUT_W  = 12;
  localparam int LVL_W       = 2;

  localparam int POS_W     = $clog2(MAX_CLASSES + BOX_FIELDS);
  localparam int ROWLEN_W  = POS_W + 1;
  localparam int IMG_EFF_W = $clog2(IMAGE_MAX) + 1;
  localparam int IMGC_W    = (IMG_EFF_W > CFG_IMG_W) ? IMG_EFF_W : CFG_IMG_W;
  localparam int GRID_W    = $clog2(IMAGE_MAX >> BASE_STRIDE_SHIFT);

  localparam int SUM_W     = ((GRID_W + VALUE_FRAC_BITS > VALUE_W) ?
                              GRID_W + VALUE_FRAC_BITS : VALUE_W) + 2;
  localparam int MAX_SHIFT = BASE_STRIDE_SHIFT + LEVELS - 1 + Q16 - VALUE_FRAC_BITS;
  localparam int SH_W      = $clog2(MAX_SHIFT + 1);
  localparam int COORD_W   = SUM_W + MAX_SHIFT;
  localparam int BOX_W     = COORD_W + 1;

  localparam int SIZE_W      = SIZE_OUT_W + Q16;
  localparam int SIZE_SAT_E  = SIZE_W - Q16;
  localparam int TAB_W       = 18;
  localparam int INTERP_BITS = VALUE_FRAC_BITS - 4;
  localparam int R_W         = TAB_W + SIZE_SAT_E - 1;
  localparam int LOG2E_W     = 18;
  localparam int Y_W         = VALUE_W + LOG2E_W - Q16;
  localparam int EXP_W       = Y_W - VALUE_FRAC_BITS + 1;

  localparam int PROD_W     = 2 * VALUE_W;
  localparam int PROB_SHIFT = 2 * VALUE_FRAC_BITS - Q16;

  localparam logic signed [LOG2E_W-1:0] LOG2E_S = LOG2E_W'(LOG2E_Q16);
  localparam logic [SIZE_W-1:0] SIZE_CAP = {{SIZE_OUT_W{1'b1}}, {Q16{1'b0}}};

  localparam logic [POS_W-1:0] POS_DX  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_DY  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LW  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LH  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_OBJ = POS_W'(4);
  localparam logic [POS_W-1:0] POS_CLS = POS_W'(BOX_FIELDS);

  typedef enum logic [2:0] {
    REG_THR    = 3'd0,
    REG_ROWS   = 3'd1,
    REG_COLS   = 3'd2,
    REG_NC     = 3'd3,
    REG_CENTER = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0]     thr;
    logic [CFG_IMG_W-1:0] rows;
    logic [CFG_IMG_W-1:0] cols;
    logic [NC_W-1:0]      nc;
    logic                 center;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [GRID_W-1:0] grid;
    logic [LVL_W-1:0]  lvl;
  } tag_t;

  // 2^(k/16) in q.16
  function automatic logic [TAB_W-1:0] pow2_frac(input logic [4:0] k);
    logic [TAB_W-1:0] v;
    case (k)
      5'd0:    v = TAB_W'(65536);
      5'd1:    v = TAB_W'(68438);
      5'd2:    v = TAB_W'(71468);
      5'd3:    v = TAB_W'(74631);
      5'd4:    v = TAB_W'(77936);
      5'd5:    v = TAB_W'(81386);
      5'd6:    v = TAB_W'(84989);
      5'd7:    v = TAB_W'(88752);
      5'd8:    v = TAB_W'(92682);
      5'd9:    v = TAB_W'(96785);
      5'd10:   v = TAB_W'(101070);
      5'd11:   v = TAB_W'(105545);
      5'd12:   v = TAB_W'(110218);
      5'd13:   v = TAB_W'(115098);
      5'd14:   v = TAB_W'(120194);
      5'd15:   v = TAB_W'(125515);
      5'd16:   v = TAB_W'(131072);
      default: v = TAB_W'(131072);
    endcase
    return v;
  endfunction

endpackage

// File: src/afd_ifs.sv
// ----------------------------------------------------------------------------
// afd channel interfaces
// valid/ready channels for tensor words in and detection words out
// ----------------------------------------------------------------------------
interface afd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] tensor_value;
  logic               first_of_frame;

  modport source (output valid, output tensor_value, output first_of_frame, input ready);
  modport sink   (input valid, input tensor_value, input first_of_frame, output ready);
endinterface

interface afd_out_if;
  logic               valid;
  logic               ready;
  logic [6:0]         class_index;
  logic [15:0]        confidence;
  logic signed [12:0] box_x;
  logic signed [12:0] box_y;
  logic [11:0]        box_w;
  logic [11:0]        box_h;

  modport source (output valid, output class_index, output confidence, output box_x,
                  output box_y, output box_w, output box_h, input ready);
  modport sink   (input valid, input class_index, input confidence, input box_x,
                  input box_y, input box_w, input box_h, output ready);
endinterface

// File: src/anchor_free_detector_decode.sv
// ----------------------------------------------------------------------------
// anchor_free_detector_decode
// decodes detector tensor words into thresholded boxes
// ----------------------------------------------------------------------------
// in_ch carries one signed q4.12 tensor word per transfer, in anchor row order
// (dx, dy, log w, log h, objectness, class scores); first_of_frame restarts at
// anchor zero. out_ch carries one detection word for each class score whose
// product with objectness beats the threshold; other words leave nothing.
// registers are to be written over the apb port only while the block is idle;
// the block itself does not enforce this. a word is taken into the input
// register, passes the multiply stage (coord shift, log2e product, objectness
// product) and the size and compare stage, and its detection lands in the
// output register. one word is taken every cycle unless a stalled detection
// holds the stages; the anchor walker and the 16x18 and 16x16 multipliers all
// run at that rate. reset returns the registers to their defaults, the walker
// to anchor zero and the box state to zero; no clearing pass is needed.
// when the receiver stalls the detection waits in the output register, and
// words keep being taken until a stalled detection reaches the size stage.
// ----------------------------------------------------------------------------
module anchor_free_detector_decode import afd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  afd_in_if.sink            in_ch,
  afd_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  tag_t tag;

  logic                       in_acc;
  logic                       out_free, s1_emit, s1_go, s1_free, s0_go, s0_free;

  logic                       s0_v_r;
  logic signed [VALUE_W-1:0]  s0_val_r;
  tag_t                       s0_tag_r;

  logic                       s1_v_r;
  logic [POS_W-1:0]           s1_pos_r;
  logic [LVL_W-1:0]           s1_lvl_r;
  logic signed [Y_W-1:0]      s1_y_r;
  logic signed [PROD_W-1:0]   s1_prod_r;

  logic signed [COORD_W-1:0]  cx_r, cy_r;
  logic [SIZE_W-1:0]          w_r, h_r;
  logic signed [VALUE_W-1:0]  obj_r;

  logic                       out_v_r;
  logic [CLASS_W-1:0]         cls_r;
  logic [CONF_W-1:0]          conf_r;
  logic signed [COORD_OUT_W-1:0] bx_r, by_r;
  logic [SIZE_OUT_W-1:0]      bw_r, bh_r;

  logic signed [SUM_W-1:0]    s0_sum;
  logic [SH_W-1:0]            s0_sh;
  logic signed [COORD_W-1:0]  s0_coord;
  logic signed [VALUE_W+LOG2E_W-1:0] s0_ly;
  logic signed [PROD_W-1:0]   s0_prod;

  logic [SIZE_W-1:0]          s1_size;
  logic [PROD_W-1:0]          s1_prob;
  logic [CONF_W-1:0]          s1_conf;
  logic signed [BOX_W-1:0]    s1_bx, s1_by;
  logic [SIZE_W-1:0]          s1_wr, s1_hr;

  function automatic logic [COORD_OUT_W-1:0] sat_coord(input logic signed [BOX_W-1:0] q);
    logic signed [BOX_W:0]       t;
    logic signed [BOX_W-Q16:0]   p;
    t = (BOX_W+1)'(q) + (BOX_W+1)'(HALF_Q16);
    p = (BOX_W-Q16+1)'(t >>> Q16);
    if (p < -(1 <<< (COORD_OUT_W-1))) begin
      return {1'b1, {(COORD_OUT_W-1){1'b0}}};
    end else if (p > ((1 <<< (COORD_OUT_W-1)) - 1)) begin
      return {1'b0, {(COORD_OUT_W-1){1'b1}}};
    end
    return p[COORD_OUT_W-1:0];
  endfunction

  afd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  afd_sched u_sched (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_acc),
    .first  (in_ch.first_of_frame),
    .cfg    (cfg),
    .tag    (tag)
  );

  afd_exp u_exp (
    .y    (s1_y_r),
    .lvl  (s1_lvl_r),
    .size (s1_size)
  );

  // handshake
  assign out_free    = !out_v_r || out_ch.ready;
  assign s1_go       = s1_v_r && (!s1_emit || out_free);
  assign s1_free     = !s1_v_r || s1_go;
  assign s0_go       = s0_v_r && s1_free;
  assign s0_free     = !s0_v_r || s0_go;
  assign in_ch.ready = s0_free;
  assign in_acc      = in_ch.valid && s0_free;

  // multiply stage
  always_comb begin
    s0_sum   = SUM_W'(s0_val_r) +
               $signed(SUM_W'({s0_tag_r.grid, {VALUE_FRAC_BITS{1'b0}}}));
    s0_sh    = SH_W'(BASE_STRIDE_SHIFT + Q16 - VALUE_FRAC_BITS) + SH_W'(s0_tag_r.lvl);
    s0_coord = COORD_W'(s0_sum) <<< s0_sh;
    s0_ly    = s0_val_r * LOG2E_S;
    s0_prod  = s0_val_r * obj_r;
  end

  // size and compare stage
  always_comb begin
    s1_prob = PROD_W'(s1_prod_r >>> PROB_SHIFT);
    s1_emit = (s1_pos_r >= POS_CLS) && (s1_prod_r > 0) && (s1_prob > PROD_W'(cfg.thr));
    s1_conf = (|s1_prob[PROD_W-1:CONF_W]) ? {CONF_W{1'b1}} : s1_prob[CONF_W-1:0];
    s1_bx   = BOX_W'(cx_r);
    s1_by   = BOX_W'(cy_r);
    if (!cfg.center) begin
      s1_bx = s1_bx - $signed(BOX_W'(w_r >> 1));
      s1_by = s1_by - $signed(BOX_W'(h_r >> 1));
    end
    s1_wr   = w_r + SIZE_W'(HALF_Q16);
    s1_hr   = h_r + SIZE_W'(HALF_Q16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      cx_r    <= '0;
      cy_r    <= '0;
      w_r     <= '0;
      h_r     <= '0;
      obj_r   <= '0;
    end else begin
      if (in_acc) begin
        s0_v_r   <= 1'b1;
        s0_val_r <= in_ch.tensor_value;
        s0_tag_r <= tag;
      end else if (s0_go) begin
        s0_v_r <= 1'b0;
      end

      if (s0_go) begin
        s1_v_r    <= 1'b1;
        s1_pos_r  <= s0_tag_r.pos;
        s1_lvl_r  <= s0_tag_r.lvl;
        s1_y_r    <= Y_W'(s0_ly >>> Q16);
        s1_prod_r <= s0_prod;
        case (s0_tag_r.pos)
          POS_DX:  cx_r  <= s0_coord;
          POS_DY:  cy_r  <= s0_coord;
          POS_OBJ: obj_r <= s0_val_r;
          default: ;
        endcase
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end

      if (s1_go) begin
        case (s1_pos_r)
          POS_LW:  w_r <= s1_size;
          POS_LH:  h_r <= s1_size;
          default: ;
        endcase
      end

      if (s1_go && s1_emit) begin
        out_v_r <= 1'b1;
        cls_r   <= CLASS_W'(s1_pos_r - POS_CLS);
        conf_r  <= s1_conf;
        bx_r    <= sat_coord(s1_bx);
        by_r    <= sat_coord(s1_by);
        bw_r    <= s1_wr[SIZE_W-1 -: SIZE_OUT_W];
        bh_r    <= s1_hr[SIZE_W-1 -: SIZE_OUT_W];
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.class_index = cls_r;
  assign out_ch.confidence  = conf_r;
  assign out_ch.box_x       = bx_r;
  assign out_ch.box_y       = by_r;
  assign out_ch.box_w       = bw_r;
  assign out_ch.box_h       = bh_r;

endmodule

// File: src/afd_cfg.sv
// ----------------------------------------------------------------------------
// afd_cfg
// apb register file holding threshold, image size, class count and box mode
// ----------------------------------------------------------------------------
module afd_cfg import afd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr    <= THR_W'(16384);
      cfg_r.rows   <= CFG_IMG_W'(640);
      cfg_r.cols   <= CFG_IMG_W'(640);
      cfg_r.nc     <= NC_W'(80);
      cfg_r.center <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_THR:    cfg_r.thr    <= pwdata[THR_W-1:0];
        REG_ROWS:   cfg_r.rows   <= pwdata[CFG_IMG_W-1:0];
        REG_COLS:   cfg_r.cols   <= pwdata[CFG_IMG_W-1:0];
        REG_NC:     cfg_r.nc     <= pwdata[NC_W-1:0];
        REG_CENTER: cfg_r.center <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_THR:    prdata = DATA_W'(cfg_r.thr);
      REG_ROWS:   prdata = DATA_W'(cfg_r.rows);
      REG_COLS:   prdata = DATA_W'(cfg_r.cols);
      REG_NC:     prdata = DATA_W'(cfg_r.nc);
      REG_CENTER: prdata = DATA_W'(cfg_r.center);
      default:    prdata = '0;
    endcase
  end

endmodule

// File: src/afd_sched.sv
// ----------------------------------------------------------------------------
// afd_sched
// anchor walker: element position, grid column and row, stride level
// ----------------------------------------------------------------------------
module afd_sched import afd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic accept,
  input  logic first,
  input  cfg_t cfg,
  output tag_t tag
);

  logic [POS_W-1:0]    pos_r, pos_nxt, pos_raw, pos_eff;
  logic [GRID_W-1:0]   gc_r, gc_nxt, gc_e;
  logic [GRID_W-1:0]   gr_r, gr_nxt, gr_e;
  logic [LVL_W-1:0]    lvl_r, lvl_nxt, lvl_e;
  logic [LVL_W:0]      lvl_inc;
  logic [NC_W-1:0]     nc_eff;
  logic [ROWLEN_W-1:0] row_len;
  logic [IMGC_W-1:0]   cols, rows;
  logic [GRID_W:0]     gc_inc, gr_inc;
  logic                last_elem;

  function automatic logic [IMGC_W-1:0] eff_image(input logic [CFG_IMG_W-1:0] r);
    logic [IMGC_W-1:0] v;
    v = IMGC_W'(r);
    if (v > IMGC_W'(IMAGE_MAX)) v = IMGC_W'(IMAGE_MAX);
    v[IMG_ALIGN-1:0] = '0;
    if (v < IMGC_W'(IMG_MIN)) v = IMGC_W'(IMG_MIN);
    return v;
  endfunction

  always_comb begin
    if (cfg.nc == '0) begin
      nc_eff = NC_W'(1);
    end else if (cfg.nc > NC_W'(MAX_CLASSES)) begin
      nc_eff = NC_W'(MAX_CLASSES);
    end else begin
      nc_eff = cfg.nc;
    end
    row_len = ROWLEN_W'(BOX_FIELDS) + ROWLEN_W'(nc_eff);

    pos_raw = first ? '0 : pos_r;
    gc_e    = first ? '0 : gc_r;
    gr_e    = first ? '0 : gr_r;
    lvl_e   = (first || lvl_r >= LVL_W'(LEVELS)) ? '0 : lvl_r;
    pos_eff = (ROWLEN_W'(pos_raw) >= row_len) ? POS_W'(row_len - ROWLEN_W'(1)) : pos_raw;

    cols    = eff_image(cfg.cols) >> (BASE_STRIDE_SHIFT + int'(lvl_e));
    rows    = eff_image(cfg.rows) >> (BASE_STRIDE_SHIFT + int'(lvl_e));
    gc_inc  = (GRID_W+1)'(gc_e) + (GRID_W+1)'(1);
    gr_inc  = (GRID_W+1)'(gr_e) + (GRID_W+1)'(1);
    lvl_inc = (LVL_W+1)'(lvl_e) + (LVL_W+1)'(1);
    last_elem = (ROWLEN_W'(pos_eff) + ROWLEN_W'(1)) >= row_len;

    pos_nxt = pos_eff + POS_W'(1);
    gc_nxt  = gc_e;
    gr_nxt  = gr_e;
    lvl_nxt = lvl_e;
    if (last_elem) begin
      pos_nxt = '0;
      if (IMGC_W'(gc_inc) >= cols) begin
        gc_nxt = '0;
        if (IMGC_W'(gr_inc) >= rows) begin
          gr_nxt  = '0;
          lvl_nxt = (lvl_inc >= (LVL_W+1)'(LEVELS)) ? '0 : lvl_inc[LVL_W-1:0];
        end else begin
          gr_nxt = gr_inc[GRID_W-1:0];
        end
      end else begin
        gc_nxt = gc_inc[GRID_W-1:0];
      end
    end

    tag.pos  = pos_eff;
    tag.grid = (pos_eff == POS_DY) ? gr_e : gc_e;
    tag.lvl  = lvl_e;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      gc_r  <= '0;
      gr_r  <= '0;
      lvl_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      gc_r  <= gc_nxt;
      gr_r  <= gr_nxt;
      lvl_r <= lvl_nxt;
    end
  end

endmodule

// File: src/afd_exp.sv
// ----------------------------------------------------------------------------
// afd_exp
// box size from log2 domain value: table plus linear interpolation, scaled
// by stride and exponent, saturated to the 4095 pixel cap
// ----------------------------------------------------------------------------
module afd_exp import afd_pkg::*; (
  input  logic signed [Y_W-1:0]   y,
  input  logic [LVL_W-1:0]        lvl,
  output logic [SIZE_W-1:0]       size
);

  logic signed [EXP_W-1:0]         e;
  logic [EXP_W-1:0]                e_neg;
  logic [3:0]                      idx;
  logic [INTERP_BITS-1:0]          rem;
  logic [TAB_W-1:0]                t0, t1, diff, mant;
  logic [TAB_W+INTERP_BITS-1:0]    step;
  logic [R_W-1:0]                  r;

  always_comb begin
    e     = EXP_W'(y >>> VALUE_FRAC_BITS) + EXP_W'(BASE_STRIDE_SHIFT) + EXP_W'(lvl);
    e_neg = EXP_W'(-e);
    idx   = y[VALUE_FRAC_BITS-1 -: 4];
    rem   = y[INTERP_BITS-1:0];
    t0    = pow2_frac({1'b0, idx});
    t1    = pow2_frac({1'b0, idx} + 5'd1);
    diff  = t1 - t0;
    step  = (TAB_W+INTERP_BITS)'(diff) * (TAB_W+INTERP_BITS)'(rem);
    mant  = t0 + TAB_W'(step >> INTERP_BITS);
    if (e >= $signed(EXP_W'(SIZE_SAT_E))) begin
      r = R_W'(SIZE_CAP);
    end else if (e >= $signed(EXP_W'(0))) begin
      r = R_W'(mant) << e[EXP_W-2:0];
    end else begin
      r = R_W'(mant) >> e_neg;
    end
    size = (r > R_W'(SIZE_CAP)) ? SIZE_CAP : SIZE_W'(r);
  end

endmodule

// File: src/afd_checker.sv
// ----------------------------------------------------------------------------
// afd_checker
// port level checks on the decoder result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "anchor_free_detector_decode_assert.svh"

module afd_checker import afd_pkg::*; (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [CLASS_W-1:0]            class_index,
  input logic [CONF_W-1:0]             confidence,
  input logic signed [COORD_OUT_W-1:0] box_x,
  input logic signed [COORD_OUT_W-1:0] box_y,
  input logic [SIZE_OUT_W-1:0]         box_w,
  input logic [SIZE_OUT_W-1:0]         box_h
);

  `AFD_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(class_index) && $stable(confidence) && $stable(box_x) && $stable(box_y) && $stable(box_w) && $stable(box_h), "stalled detection word changed")
  `AFD_ASSERT(a_conf_nonzero, clk, rst_n, out_valid |-> confidence != '0, "detection with zero confidence")
  `AFD_ASSERT(a_class_range, clk, rst_n, out_valid |-> class_index < CLASS_W'(MAX_CLASSES), "class index out of range")
  `AFD_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "detection shown after reset")

endmodule

bind anchor_free_detector_decode afd_checker u_afd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .class_index (out_ch.class_index),
  .confidence  (out_ch.confidence),
  .box_x       (out_ch.box_x),
  .box_y       (out_ch.box_y),
  .box_w       (out_ch.box_w),
  .box_h       (out_ch.box_h)
);

// File: bench/tb_anchor_free_detector_decode.sv
// ----------------------------------------------------------------------------
// tb_anchor_free_detector_decode
// streams detector tensor words through the decoder and checks every detection
// word against a box decoder kept in step with the walker, under random idling
// on both channels, register changes between phases and a long output stall
// ----------------------------------------------------------------------------
module tb_anchor_free_detector_decode;
  timeunit 1ns;
  timeprecision 1ps;
  import afd_pkg::*;

  localparam int     FRAC          = VALUE_FRAC_BITS;
  localparam longint SIZE_LIMIT    = longint'(4095) <<< Q16;
  localparam int     SETTLE_CYCLES = 8;
  localparam int     HOLD_CYCLES   = 300;
  localparam int     MAX_SHOWN     = 10;

  typedef struct packed {
    logic [6:0]         cls;
    logic [15:0]        conf;
    logic signed [12:0] x;
    logic signed [12:0] y;
    logic [11:0]        w;
    logic [11:0]        h;
  } detection_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  afd_in_if  in_ch ();
  afd_out_if out_ch ();

  anchor_free_detector_decode dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // register copies
  int   thr_q16 = 16384;
  int   rows_reg = 640;
  int   cols_reg = 640;
  int   class_reg = 80;
  logic centre_mode = 1'b0;

  // anchor walker and box state
  int     walk_pos = 0;
  int     walk_col = 0;
  int     walk_row = 0;
  int     walk_lvl = 0;
  longint ctr_x = 0;
  longint ctr_y = 0;
  longint size_w = 0;
  longint size_h = 0;
  longint obj_raw = 0;

  detection_t expected_dets[$];
  int         mismatch_count = 0;

  bit tx_throttle = 1'b1;
  bit rx_throttle = 1'b1;
  bit dense_hits = 1'b0;
  int hold_req_cnt = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint pow2_step(input int k);
    case (k)
      0:       return 65536;
      1:       return 68438;
      2:       return 71468;
      3:       return 74631;
      4:       return 77936;
      5:       return 81386;
      6:       return 84989;
      7:       return 88752;
      8:       return 92682;
      9:       return 96785;
      10:      return 101070;
      11:      return 105545;
      12:      return 110218;
      13:      return 115098;
      14:      return 120194;
      15:      return 125515;
      default: return 131072;
    endcase
  endfunction

  function automatic longint exp_scaled(input longint v, input longint stride);
    longint y, n, fr, idx, rem, m, r;
    y = (v * LOG2E_Q16) >>> Q16;
    n = y >>> FRAC;
    fr = y - (n <<< FRAC);
    idx = fr >>> (FRAC - 4);
    rem = fr & ((longint'(1) <<< (FRAC - 4)) - 1);
    m = pow2_step(int'(idx)) +
        (((pow2_step(int'(idx) + 1) - pow2_step(int'(idx))) * rem) >>> (FRAC - 4));
    r = m * stride;
    if (n >= 0) begin
      if (n > 14) return SIZE_LIMIT;
      r = r <<< n;
    end else if (-n >= 40) begin
      r = 0;
    end else begin
      r = r >>> (-n);
    end
    return (r > SIZE_LIMIT) ? SIZE_LIMIT : r;
  endfunction

  function automatic int eff_img(input int r);
    int v;
    v = (r > IMAGE_MAX) ? IMAGE_MAX : r;
    v = v & ~(IMG_MIN - 1);
    return (v < IMG_MIN) ? IMG_MIN : v;
  endfunction

  function automatic int class_count();
    if (class_reg < 1) return 1;
    return (class_reg > MAX_CLASSES) ? MAX_CLASSES : class_reg;
  endfunction

  function automatic logic signed [12:0] pixel_coord(input longint q);
    longint p;
    p = (q + HALF_Q16) >>> Q16;
    if (p < -4096) p = -4096;
    if (p > 4095) p = 4095;
    return 13'(p);
  endfunction

  function automatic logic [11:0] pixel_size(input longint q);
    longint p;
    p = (q + HALF_Q16) >>> Q16;
    if (p < 0) p = 0;
    if (p > 4095) p = 4095;
    return 12'(p);
  endfunction

  function automatic void decode_word(input logic signed [15:0] word, input logic restart);
    longint     val, stride, prob, bx, by;
    int         row_len, lvl, cols, rows;
    detection_t det;
    val = longint'(word);
    row_len = BOX_FIELDS + class_count();
    lvl = (walk_lvl < LEVELS) ? walk_lvl : 0;
    if (restart) begin
      walk_pos = 0;
      walk_col = 0;
      walk_row = 0;
      walk_lvl = 0;
      lvl = 0;
    end
    stride = longint'(1) <<< (BASE_STRIDE_SHIFT + lvl);
    if (walk_pos >= row_len) walk_pos = row_len - 1;
    case (POS_W'(walk_pos))
      POS_DX:  ctr_x = (val + (longint'(walk_col) <<< FRAC)) * stride <<< (Q16 - FRAC);
      POS_DY:  ctr_y = (val + (longint'(walk_row) <<< FRAC)) * stride <<< (Q16 - FRAC);
      POS_LW:  size_w = exp_scaled(val, stride);
      POS_LH:  size_h = exp_scaled(val, stride);
      POS_OBJ: obj_raw = val;
      default: begin
        prob = obj_raw * val;
        if (prob > 0) begin
          prob = prob >>> (2 * FRAC - Q16);
          if (prob > thr_q16) begin
            bx = ctr_x;
            by = ctr_y;
            if (!centre_mode) begin
              bx = bx - (size_w >>> 1);
              by = by - (size_h >>> 1);
            end
            det.cls = 7'(walk_pos - BOX_FIELDS);
            det.conf = (prob > 65535) ? 16'hFFFF : 16'(prob);
            det.x = pixel_coord(bx);
            det.y = pixel_coord(by);
            det.w = pixel_size(size_w);
            det.h = pixel_size(size_h);
            expected_dets.insert(expected_dets.size(), det);
          end
        end
      end
    endcase
    if (walk_pos + 1 >= row_len) begin
      cols = eff_img(cols_reg) / int'(stride);
      rows = eff_img(rows_reg) / int'(stride);
      walk_pos = 0;
      walk_col++;
      if (walk_col >= cols) begin
        walk_col = 0;
        walk_row++;
        if (walk_row >= rows) begin
          walk_row = 0;
          walk_lvl = lvl + 1;
          if (walk_lvl >= LEVELS) walk_lvl = 0;
        end
      end
    end else begin
      walk_pos++;
    end
  endfunction

  function automatic int full_word();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int shape_word(input logic restart);
    int pos;
    pos = restart ? 0 : walk_pos;
    if (pos >= BOX_FIELDS + class_count()) pos = BOX_FIELDS + class_count() - 1;
    if (pos < int'(POS_LW)) return full_word();
    if (pos < int'(POS_OBJ)) begin
      if ($urandom_range(0, 4) == 0) return full_word();
      return int'($urandom_range(0, 24576)) - 12288;
    end
    if (pos == int'(POS_OBJ)) begin
      if (dense_hits) return int'($urandom_range(8192, 32767));
      if ($urandom_range(0, 3) == 0) return full_word();
      return int'($urandom_range(2048, 32767));
    end
    if (dense_hits) return int'($urandom_range(4096, 32767));
    if ($urandom_range(0, 9) < 3) return full_word();
    return int'($urandom_range(0, 8191));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      decode_word(in_ch.tensor_value, in_ch.first_of_frame);
  end

  always @(posedge clk) begin : check_results
    detection_t want, got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.cls = out_ch.class_index;
      got.conf = out_ch.confidence;
      got.x = out_ch.box_x;
      got.y = out_ch.box_y;
      got.w = out_ch.box_w;
      got.h = out_ch.box_h;
      if (expected_dets.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("unexpected detection word: cls %0d conf %0d box %0d %0d %0d %0d",
                   got.cls, got.conf, got.x, got.y, got.w, got.h);
      end else begin
        want = expected_dets.pop_front();
        if (want.cls !== got.cls || want.conf !== got.conf || want.x !== got.x ||
            want.y !== got.y || want.w !== got.w || want.h !== got.h) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display({"detection mismatch: exp cls %0d conf %0d box %0d %0d %0d %0d,",
                      " got cls %0d conf %0d box %0d %0d %0d %0d"},
                     want.cls, want.conf, want.x, want.y, want.w, want.h,
                     got.cls, got.conf, got.x, got.y, got.w, got.h);
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin : drive_ready
    static int hold_left = 0;
    static int hold_seen = 0;
    static int rx_run = 0;
    static bit rx_level = 1'b1;
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_seen != hold_req_cnt) begin
      hold_seen = hold_req_cnt;
      hold_left = HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else if (!rx_throttle) begin
      out_ch.ready <= 1'b1;
    end else begin
      if (rx_run == 0) begin
        rx_level = ($urandom_range(0, 99) < 70);
        if (rx_level) rx_run = $urandom_range(1, 8);
        else if ($urandom_range(0, 99) < 90) rx_run = $urandom_range(1, 3);
        else rx_run = $urandom_range(15, 60);
      end
      rx_run--;
      out_ch.ready <= rx_level;
    end
  end

  task automatic send_word(input int word, input logic restart, input bit shaped);
    int gap;
    gap = tx_throttle ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    if (shaped) word = shape_word(restart);
    in_ch.valid <= 1'b1;
    in_ch.tensor_value <= 16'(word);
    in_ch.first_of_frame <= restart;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic settle_block();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_dets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int unsigned value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(int'(idx) * 4);
    pwdata <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_THR:    thr_q16 = int'(value & 32'hFFFF);
      REG_ROWS:   rows_reg = int'(value & 32'h7FF);
      REG_COLS:   cols_reg = int'(value & 32'h7FF);
      REG_NC:     class_reg = int'(value & 32'h7F);
      REG_CENTER: centre_mode = value[0];
      default:    ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_stream(input int count, input bit fresh);
    for (int i = 0; i < count; i++)
      send_word(0, (i == 0 && fresh) || ($urandom_range(0, 49) == 0), 1'b1);
  endtask

  // reset settings, extreme box fields, saturated, negative and zero products
  task automatic test_default_row();
    send_word(-32768, 1'b1, 1'b0);
    send_word(32767, 1'b0, 1'b0);
    send_word(32767, 1'b0, 1'b0);
    send_word(-32768, 1'b0, 1'b0);
    send_word(32767, 1'b0, 1'b0);
    send_word(32767, 1'b0, 1'b0);
    send_word(-32768, 1'b0, 1'b0);
    send_word(0, 1'b0, 1'b0);
  endtask

  // zero threshold, clamped image and class count, centre output
  task automatic test_modes_and_clamps();
    settle_block();
    write_reg(REG_THR, 0);
    write_reg(REG_ROWS, 0);
    write_reg(REG_COLS, 2047);
    write_reg(REG_NC, 0);
    write_reg(REG_CENTER, 1);
    send_word(0, 1'b1, 1'b0);
    send_word(0, 1'b0, 1'b0);
    send_word(0, 1'b0, 1'b0);
    send_word(0, 1'b0, 1'b0);
    send_word(-4096, 1'b0, 1'b0);
    send_word(-4096, 1'b0, 1'b0);
    send_word(4095, 1'b0, 1'b0);
    send_word(-1, 1'b0, 1'b0);
    send_word(8192, 1'b0, 1'b0);
    send_word(-8192, 1'b0, 1'b0);
    send_word(1, 1'b0, 1'b0);
    send_word(1, 1'b0, 1'b0);
  endtask

  // class count shrinks while the walker sits mid row
  task automatic test_mid_row_shrink();
    settle_block();
    write_reg(REG_THR, 65535);
    write_reg(REG_NC, 4);
    write_reg(REG_CENTER, 0);
    send_word(100, 1'b1, 1'b0);
    send_word(-100, 1'b0, 1'b0);
    send_word(4096, 1'b0, 1'b0);
    send_word(2048, 1'b0, 1'b0);
    send_word(32767, 1'b0, 1'b0);
    send_word(32767, 1'b0, 1'b0);
    settle_block();
    write_reg(REG_NC, 1);
    send_word(32767, 1'b0, 1'b0);
  endtask

  // smallest image, run past the last level back to anchor zero
  task automatic test_level_wrap();
    settle_block();
    write_reg(REG_THR, 20000);
    write_reg(REG_ROWS, 32);
    write_reg(REG_COLS, 32);
    write_reg(REG_NC, 1);
    write_reg(REG_CENTER, $urandom_range(0, 1));
    for (int i = 0; i < 140; i++) send_word(0, i == 0, 1'b1);
  endtask

  // widest image so the column counter reaches its top value
  task automatic test_wide_grid();
    settle_block();
    write_reg(REG_THR, 40000);
    write_reg(REG_ROWS, 32);
    write_reg(REG_COLS, 1024);
    write_reg(REG_NC, 1);
    for (int i = 0; i < 780; i++) send_word(0, i == 0, 1'b1);
  endtask

  // receiver holds off while every class score hits
  task automatic test_output_backpressure();
    settle_block();
    write_reg(REG_THR, 0);
    write_reg(REG_ROWS, 32);
    write_reg(REG_COLS, 32);
    write_reg(REG_NC, 3);
    write_reg(REG_CENTER, $urandom_range(0, 1));
    tx_throttle = 1'b0;
    rx_throttle = 1'b0;
    dense_hits = 1'b1;
    hold_req_cnt++;
    for (int i = 0; i < 120; i++) send_word(0, i == 0, 1'b1);
    settle_block();
    dense_hits = 1'b0;
    tx_throttle = 1'b1;
    rx_throttle = 1'b1;
  endtask

  function automatic int pick_image();
    if ($urandom_range(0, 9) < 7) return 32 * $urandom_range(1, 2);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 31;
      2:       return 100;
      3:       return 1024;
      4:       return 2047;
      default: return $urandom_range(0, 2047);
    endcase
  endfunction

  task automatic test_random_phases();
    int sent, count, pick;
    sent = 0;
    while (sent < 800) begin
      settle_block();
      pick = $urandom_range(0, 9);
      write_reg(REG_THR, (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(0, 65535));
      write_reg(REG_ROWS, pick_image());
      write_reg(REG_COLS, pick_image());
      pick = $urandom_range(0, 9);
      if (pick < 7) write_reg(REG_NC, $urandom_range(1, 4));
      else if (pick == 7) write_reg(REG_NC, 0);
      else if (pick == 8) write_reg(REG_NC, $urandom_range(0, 1) ? 80 : 127);
      else write_reg(REG_NC, $urandom_range(0, 127));
      write_reg(REG_CENTER, $urandom_range(0, 1));
      tx_throttle = ($urandom_range(0, 3) != 0);
      rx_throttle = ($urandom_range(0, 3) != 0);
      count = $urandom_range(40, 140);
      send_stream(count, $urandom_range(0, 99) < 85);
      sent += count;
    end
    tx_throttle = 1'b1;
    rx_throttle = 1'b1;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.tensor_value = '0;
    in_ch.first_of_frame = 1'b0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_default_row();
    test_modes_and_clamps();
    test_mid_row_shrink();
    test_level_wrap();
    test_wide_grid();
    test_output_backpressure();
    test_random_phases();
    settle_block();
    if (mismatch_count == 0 && expected_dets.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
